@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands clocked on aclk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every aclk edge while reset is released.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check on every aclk edge, reset included.
`define ASSERT_CLK_ALL(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ rtl/rdm_pkg.sv @@
// ----------------------------------------------------------------------------
// rdm_pkg
// Shared types, register map and constants of the ducking reverb mixer.
// ----------------------------------------------------------------------------
package rdm_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // Register reset values
    localparam logic [15:0] THRESHOLD_RST = 16'd1966;
    localparam logic [15:0] RECIP_RST     = 16'd4267;
    localparam logic [15:0] DEPTH_RST     = 16'd53620;
    localparam logic [15:0] RELEASE_RST   = 16'd8192;
    localparam logic [15:0] WET_MIX_RST   = 16'd22938;
    localparam logic [15:0] MAKEUP_RST    = 16'd40960;
    localparam logic        STEREO_RST    = 1'b1;
    localparam logic        BYPASS_RST    = 1'b0;

    // 0.001 in Q0.16, unity and 0.01 gain in Q0.16 (17 bits for unity)
    localparam logic [15:0] ATTACK_COEF = 16'd66;
    localparam logic [16:0] GAIN_ONE    = 17'h10000;
    localparam logic [16:0] GAIN_FLOOR  = 17'd655;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_THRESHOLD = 3'd0,
        REG_RECIP     = 3'd1,
        REG_DEPTH     = 3'd2,
        REG_RELEASE   = 3'd3,
        REG_WET_MIX   = 3'd4,
        REG_MAKEUP    = 3'd5,
        REG_STEREO    = 3'd6,
        REG_BYPASS    = 3'd7
    } cfg_idx_t;

    // Datapath step codes issued by the sequencer
    typedef enum logic [3:0] {
        OP_NONE      = 4'd0,
        OP_LOAD      = 4'd1,
        OP_ENV_MUL   = 4'd2,
        OP_ENV_UPD   = 4'd3,
        OP_EXC_MUL   = 4'd4,
        OP_EXC_CLAMP = 4'd5,
        OP_RED_MUL   = 4'd6,
        OP_GAIN      = 4'd7,
        OP_G_MUL     = 4'd8,
        OP_DM_MUL    = 4'd9,
        OP_WG_MUL    = 4'd10,
        OP_WM_MUL    = 4'd11,
        OP_SUM       = 4'd12,
        OP_RND       = 4'd13,
        OP_EMIT      = 4'd14
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   chan;   // 0 left, 1 right
    } rdm_cmd_t;

    typedef struct packed {
        logic bypass;
        logic stereo;
    } rdm_stat_t;

endpackage

@@ rtl/reverb_ducking_mixer.sv @@
// Sequence: a frame runs the envelope and gain steps, then the mix steps for the left channel
//   and again for the right in stereo, while bypass goes straight to emit; every product passes
//   in turn through the single shared multiplier, and no new frame is taken until emit.
// A finished frame waits in the output register while the next frame is taken in.
// Reset: synchronous active-low aresetn clears the envelope, the handshakes and loads
//   the register defaults.
// ----------------------------------------------------------------------------
// reverb_ducking_mixer
// Sidechain ducker: dry-level envelope follower lowers the reverb gain, then
// mixes dry and wet with makeup gain and 16-bit saturation; bypass passes dry through.
// ----------------------------------------------------------------------------
module reverb_ducking_mixer (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // dry_left[15:0], dry_right[31:16], wet_left[47:32], wet_right[63:48]
    input  logic [4*rdm_pkg::SAMPLE_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // out_left[15:0], out_right[31:16]
    output logic [2*rdm_pkg::SAMPLE_W-1:0]     m_tdata,
    input  logic                               cfg_wr_en,
    input  logic [rdm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [rdm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import rdm_pkg::*;

    rdm_cmd_t  cmd;
    rdm_stat_t stat;

    rdm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rdm_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .m_tdata   (m_tdata)
    );

endmodule

@@ rtl/rdm_ctrl.sv @@
// ----------------------------------------------------------------------------
// rdm_ctrl
// Sequencer: walks one frame through the shared multiplier and owns the
// stream handshakes.
// ----------------------------------------------------------------------------
module rdm_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  rdm_pkg::rdm_stat_t stat,
    output rdm_pkg::rdm_cmd_t  cmd
);
    import rdm_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE      = 14'b00000000000001,
        S_ENV_MUL   = 14'b00000000000010,
        S_ENV_UPD   = 14'b00000000000100,
        S_EXC_MUL   = 14'b00000000001000,
        S_EXC_CLAMP = 14'b00000000010000,
        S_RED_MUL   = 14'b00000000100000,
        S_GAIN      = 14'b00000001000000,
        S_G_MUL     = 14'b00000010000000,
        S_DM_MUL    = 14'b00000100000000,
        S_WG_MUL    = 14'b00001000000000,
        S_WM_MUL    = 14'b00010000000000,
        S_SUM       = 14'b00100000000000,
        S_RND       = 14'b01000000000000,
        S_EMIT      = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   chan_reg, chan_next;
    logic   out_valid_reg, out_valid_next;
    logic   emit;

    always_comb begin
        state_next = state_reg;
        chan_next  = chan_reg;
        cmd.op     = OP_NONE;
        cmd.chan   = chan_reg;
        emit       = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    chan_next  = 1'b0;
                    state_next = stat.bypass ? S_EMIT : S_ENV_MUL;
                end
            end
            S_ENV_MUL: begin
                cmd.op     = OP_ENV_MUL;
                state_next = S_ENV_UPD;
            end
            S_ENV_UPD: begin
                cmd.op     = OP_ENV_UPD;
                state_next = S_EXC_MUL;
            end
            S_EXC_MUL: begin
                cmd.op     = OP_EXC_MUL;
                state_next = S_EXC_CLAMP;
            end
            S_EXC_CLAMP: begin
                cmd.op     = OP_EXC_CLAMP;
                state_next = S_RED_MUL;
            end
            S_RED_MUL: begin
                cmd.op     = OP_RED_MUL;
                state_next = S_GAIN;
            end
            S_GAIN: begin
                cmd.op     = OP_GAIN;
                state_next = S_G_MUL;
            end
            S_G_MUL: begin
                cmd.op     = OP_G_MUL;
                state_next = S_DM_MUL;
            end
            S_DM_MUL: begin
                cmd.op     = OP_DM_MUL;
                state_next = S_WG_MUL;
            end
            S_WG_MUL: begin
                cmd.op     = OP_WG_MUL;
                state_next = S_WM_MUL;
            end
            S_WM_MUL: begin
                cmd.op     = OP_WM_MUL;
                state_next = S_SUM;
            end
            S_SUM: begin
                cmd.op     = OP_SUM;
                state_next = S_RND;
            end
            S_RND: begin
                cmd.op = OP_RND;
                // run the right channel only in stereo
                if (!chan_reg && stat.stereo) begin
                    chan_next  = 1'b1;
                    state_next = S_DM_MUL;
                end else begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready) begin
                    cmd.op     = OP_EMIT;
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            chan_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            chan_reg      <= chan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

@@ rtl/rdm_datapath.sv @@
// ----------------------------------------------------------------------------
// rdm_datapath
// Register file, envelope state and one shared 33x18 multiplier with its
// operand select, driven step by step from the sequencer.
// ----------------------------------------------------------------------------
module rdm_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  rdm_pkg::rdm_cmd_t                  cmd,
    output rdm_pkg::rdm_stat_t                 stat,
    input  logic [4*rdm_pkg::SAMPLE_W-1:0]     s_tdata,
    input  logic                               cfg_wr_en,
    input  logic [rdm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [rdm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output logic [2*rdm_pkg::SAMPLE_W-1:0]     m_tdata
);
    import rdm_pkg::*;

    localparam logic signed [50:0] ENV_HALF = 51'sd32768;
    localparam logic signed [51:0] OUT_HALF = 52'sd1073741824;
    localparam logic signed [51:0] SAT_MAX  = 52'sd32767;
    localparam logic signed [51:0] SAT_MIN  = -52'sd32768;

    function automatic logic [16:0] abs17(input logic signed [15:0] x);
        logic signed [16:0] xe;
        logic signed [16:0] xn;
        xe = {x[15], x};
        xn = -xe;
        return xe[16] ? xn : xe;
    endfunction

    // Configuration registers
    logic [15:0] thr_reg, recip_reg, depth_reg, rel_reg, wmix_reg, mk_reg;
    logic        stereo_reg, bypass_reg;
    logic [16:0] env_reg, env_next;

    // Working registers of the current frame
    logic signed [15:0] dl_reg, dr_reg, wl_reg, wr_reg;
    logic signed [15:0] res_l_reg, res_r_reg, out_l_reg, out_r_reg;
    logic [16:0]        level_reg, level_next;
    logic               over_reg;
    logic [16:0]        tmp_reg;
    logic [15:0]        g_reg;
    logic signed [50:0] prod_reg;
    logic signed [32:0] acc_reg;
    logic signed [51:0] sum_reg, sum_next;

    logic signed [15:0] in_dl, in_dr, in_wl, in_wr;
    logic [16:0]        abs_l, abs_r;
    logic signed [17:0] env_diff;
    logic [15:0]        env_coef;
    logic signed [50:0] env_rnd, env_delta;
    logic [16:0]        exc_diff;
    logic [43:0]        ex_wide;
    logic [16:0]        ex_clamp;
    logic [16:0]        gain_raw, gain_fl, gain_next;
    logic signed [15:0] dry_sel, wet_sel;
    logic signed [32:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [50:0] mul_p;
    logic               mul_en;
    logic signed [51:0] q_out;
    logic signed [15:0] sat_out;

    assign in_dl = s_tdata[15:0];
    assign in_dr = s_tdata[31:16];
    assign in_wl = s_tdata[47:32];
    assign in_wr = s_tdata[63:48];

    assign abs_l      = abs17(in_dl);
    assign abs_r      = abs17(in_dr);
    assign level_next = (stereo_reg && (abs_r > abs_l)) ? abs_r : abs_l;

    // Envelope: fast attack while rising, configurable release while falling
    assign env_diff  = $signed({1'b0, level_reg}) - $signed({1'b0, env_reg});
    assign env_coef  = (level_reg > env_reg) ? ATTACK_COEF : rel_reg;
    assign env_rnd   = prod_reg + ENV_HALF;
    assign env_delta = env_rnd >>> 16;
    assign env_next  = env_reg + env_delta[16:0];

    assign exc_diff = env_reg - {1'b0, thr_reg};
    assign ex_wide  = prod_reg[50:7];
    assign ex_clamp = (ex_wide > 44'd65536) ? GAIN_ONE : ex_wide[16:0];

    assign gain_raw  = GAIN_ONE - {1'b0, prod_reg[31:16]};
    assign gain_fl   = (gain_raw < GAIN_FLOOR) ? GAIN_FLOOR : gain_raw;
    assign gain_next = over_reg ? gain_fl : GAIN_ONE;

    assign dry_sel = cmd.chan ? dr_reg : dl_reg;
    assign wet_sel = cmd.chan ? wr_reg : wl_reg;

    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        case (cmd.op)
            OP_ENV_MUL: begin
                mul_a = {{15{env_diff[17]}}, env_diff};
                mul_b = {2'b00, env_coef};
            end
            OP_EXC_MUL: begin
                mul_a = {16'h0, exc_diff};
                mul_b = {2'b00, recip_reg};
            end
            OP_RED_MUL: begin
                mul_a = {16'h0, tmp_reg};
                mul_b = {2'b00, depth_reg};
            end
            OP_G_MUL: begin
                mul_a = {16'h0, tmp_reg};
                mul_b = {2'b00, wmix_reg};
            end
            OP_DM_MUL: begin
                mul_a = {{17{dry_sel[15]}}, dry_sel};
                mul_b = {2'b00, mk_reg};
            end
            OP_WG_MUL: begin
                mul_a = {{17{wet_sel[15]}}, wet_sel};
                mul_b = {2'b00, g_reg};
            end
            OP_WM_MUL: begin
                mul_a = prod_reg[32:0];
                mul_b = {2'b00, mk_reg};
            end
            default: mul_en = 1'b0;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // (dry*mk << 16) + wet*g*mk, plus half an output LSB
    assign sum_next = $signed({{3{acc_reg[32]}}, acc_reg, 16'h0})
                    + $signed({prod_reg[50], prod_reg}) + OUT_HALF;

    assign q_out = sum_reg >>> 31;

    always_comb begin
        if (q_out > SAT_MAX) begin
            sat_out = 16'sh7fff;
        end else if (q_out < SAT_MIN) begin
            sat_out = -16'sh8000;
        end else begin
            sat_out = q_out[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg    <= THRESHOLD_RST;
            recip_reg  <= RECIP_RST;
            depth_reg  <= DEPTH_RST;
            rel_reg    <= RELEASE_RST;
            wmix_reg   <= WET_MIX_RST;
            mk_reg     <= MAKEUP_RST;
            stereo_reg <= STEREO_RST;
            bypass_reg <= BYPASS_RST;
            env_reg    <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_THRESHOLD: thr_reg    <= cfg_wdata;
                    REG_RECIP:     recip_reg  <= cfg_wdata;
                    REG_DEPTH:     depth_reg  <= cfg_wdata;
                    REG_RELEASE:   rel_reg    <= cfg_wdata;
                    REG_WET_MIX:   wmix_reg   <= cfg_wdata;
                    REG_MAKEUP:    mk_reg     <= cfg_wdata;
                    REG_STEREO:    stereo_reg <= cfg_wdata[0];
                    REG_BYPASS:    bypass_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (cmd.op == OP_ENV_UPD) begin
                env_reg <= env_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= mul_p;
        end
        case (cmd.op)
            OP_LOAD: begin
                dl_reg    <= in_dl;
                dr_reg    <= in_dr;
                wl_reg    <= in_wl;
                wr_reg    <= in_wr;
                level_reg <= level_next;
                // dry values stand as the result for bypass and mono right
                res_l_reg <= in_dl;
                res_r_reg <= in_dr;
            end
            OP_EXC_MUL:   over_reg <= (env_reg > {1'b0, thr_reg});
            OP_EXC_CLAMP: tmp_reg  <= ex_clamp;
            OP_GAIN:      tmp_reg  <= gain_next;
            OP_DM_MUL: begin
                if (!cmd.chan) begin
                    g_reg <= prod_reg[31:16];
                end
            end
            OP_WG_MUL:    acc_reg <= prod_reg[32:0];
            OP_SUM:       sum_reg <= sum_next;
            OP_RND: begin
                if (cmd.chan) begin
                    res_r_reg <= sat_out;
                end else begin
                    res_l_reg <= sat_out;
                end
            end
            OP_EMIT: begin
                out_l_reg <= res_l_reg;
                out_r_reg <= res_r_reg;
            end
            default: ;
        endcase
    end

    assign stat.bypass = bypass_reg;
    assign stat.stereo = stereo_reg;
    assign m_tdata     = {out_r_reg, out_l_reg};

endmodule

@@ rtl/rdm_checker.sv @@
// ----------------------------------------------------------------------------
// rdm_checker
// Port-level checks of the ducking reverb mixer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rdm_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [2*rdm_pkg::SAMPLE_W-1:0] m_tdata
);

    `ASSERT_CLK(a_out_hold_valid, m_tvalid && !m_tready |=> m_tvalid, "result beat dropped")
    `ASSERT_CLK(a_out_hold_data, m_tvalid && !m_tready |=> $stable(m_tdata), "result beat changed")
    // one frame in flight: input closes right after a beat
    `ASSERT_CLK(a_in_one_frame, s_tvalid && s_tready |=> !s_tready, "second frame taken")
    // a new result appears only as the sequencer returns to idle
    `ASSERT_CLK(a_emit_idle, $rose(m_tvalid) |-> s_tready, "result without return to idle")

endmodule

bind reverb_ducking_mixer rdm_checker u_rdm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
